// ===== src/afr_pkg.sv =====
// Shared constants, types and command/status structs for the API frame receiver.
// Used by the top level, the controller and the datapath; depends on nothing else.
`default_nettype none

package afr_pkg;

  localparam int MaxFrame     = 32;
  localparam int PayloadBytes = 8;

  localparam int AddrBytes = 8;
  localparam int AddrAt    = 4;
  localparam int PayloadAt = 14;
  localparam int NumOut    = AddrBytes + PayloadBytes;
  localparam int LenMax    = MaxFrame - 4;
  localparam int LenRx64   = 11 + PayloadBytes;

  localparam int ByteW  = 8;
  localparam int IdxW   = 5;
  localparam int AddrW  = $clog2(MaxFrame);
  localparam int PosW   = $clog2(MaxFrame + 1);
  localparam int OutDataW = 16;

  localparam logic [ByteW-1:0] Delim    = 8'h7E;
  localparam logic [ByteW-1:0] SumOk    = 8'hFF;
  localparam logic [ByteW-1:0] TypeRx64 = 8'h80;

  typedef enum logic [1:0] {
    StRx,
    StRead,
    StLoad,
    StSend
  } state_e;

  typedef struct packed {
    logic take;
    logic rd;
    logic load;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic frame_ok;
    logic out_last;
  } status_t;

endpackage

`default_nettype wire

// ===== src/api_frame_receiver.sv =====
// Top level of the API frame receiver: joins the controller and the datapath.
// Uses afr_pkg, afr_ctrl and afr_dp.
//
// The slave stream carries received serial bytes, one per request, with a
// line-error flag in tuser. Bytes are taken one per cycle while no frame is
// being read out. When the checksum byte of a good receive frame with a
// 64-bit source address is taken, the master stream gives a run of 8 address
// bytes followed by the payload bytes, the last one marked by tlast.
// After the checksum byte is taken, each result goes in order through a frame
// store read, an output register load and a send, as the single read port of
// the frame store is used once per result. While the run is out, the slave
// side is not ready; if the receiver stalls, the current result holds and the
// block waits. Reset clears the byte counter and the controller, so the parser
// hunts for a delimiter; the frame store needs no clearing, as each frame
// rewrites what it reads.
`default_nettype none

module api_frame_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser_i,   // [0] line_error
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] out_byte, [12:8] out_index, zero above
  output logic             m_axis_tuser_o,   // [0] is_address
  output logic             m_axis_tlast_o
);

  afr_pkg::cmd_t                cmd;
  afr_pkg::status_t             status;
  logic [afr_pkg::ByteW-1:0]    out_byte;
  logic [afr_pkg::IdxW-1:0]     out_index;

  afr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid_i),
    .m_tready_i(m_axis_tready_i),
    .status_i  (status),
    .s_tready_o(s_axis_tready_o),
    .m_tvalid_o(m_axis_tvalid_o),
    .cmd_o     (cmd)
  );

  afr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .rx_byte_i   (s_axis_tdata_i),
    .line_error_i(s_axis_tuser_i),
    .status_o    (status),
    .out_byte_o  (out_byte),
    .out_index_o (out_index),
    .is_address_o(m_axis_tuser_o),
    .last_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {
    (afr_pkg::OutDataW - afr_pkg::IdxW - afr_pkg::ByteW)'(0), out_index, out_byte
  };

endmodule

`default_nettype wire

// ===== src/afr_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module afr_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/afr_dp.sv =====
// Datapath of the frame receiver: byte counter, length, running checksum,
// frame store and the output register. Uses afr_pkg and afr_ram.
`default_nettype none

module afr_dp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire afr_pkg::cmd_t             cmd_i,
  input  wire logic [afr_pkg::ByteW-1:0] rx_byte_i,
  input  wire logic                      line_error_i,
  output afr_pkg::status_t               status_o,
  output logic [afr_pkg::ByteW-1:0]      out_byte_o,
  output logic [afr_pkg::IdxW-1:0]       out_index_o,
  output logic                           is_address_o,
  output logic                           last_o
);

  logic [afr_pkg::PosW-1:0]  pos_q, pos_d, pos_inc;
  logic [afr_pkg::PosW-1:0]  len_q, len_d;
  logic [afr_pkg::ByteW-1:0] sum_q, sum_d;
  logic [afr_pkg::ByteW-1:0] type_q, type_d, type_now;
  logic [afr_pkg::IdxW-1:0]  idx_q, idx_d;
  logic                      store_en, reject, complete;
  logic [afr_pkg::AddrW-1:0] raddr;
  logic [afr_pkg::ByteW-1:0] rdata;

  always_comb begin
    reject = line_error_i
          || ((pos_q == afr_pkg::PosW'(1)) && (rx_byte_i != '0))
          || ((pos_q == afr_pkg::PosW'(2)) && (rx_byte_i > afr_pkg::ByteW'(afr_pkg::LenMax)))
          || (pos_q >= afr_pkg::PosW'(afr_pkg::MaxFrame));
    store_en = cmd_i.take && !reject
            && !((pos_q == '0) && (rx_byte_i != afr_pkg::Delim));
    pos_inc  = pos_q + afr_pkg::PosW'(1);

    // The checksum covers everything from the frame type onward.
    sum_d    = (pos_q == afr_pkg::PosW'(3)) ? rx_byte_i : sum_q + rx_byte_i;
    type_now = (pos_q == afr_pkg::PosW'(3)) ? rx_byte_i : type_q;
    complete = store_en && (pos_q >= afr_pkg::PosW'(3))
            && (pos_inc == len_q + afr_pkg::PosW'(4));

    status_o.frame_ok = complete && (sum_d == afr_pkg::SumOk)
                     && (type_now == afr_pkg::TypeRx64)
                     && (afr_pkg::ByteW'(len_q) == afr_pkg::ByteW'(afr_pkg::LenRx64));
    status_o.out_last = last_o;

    pos_d  = pos_q;
    len_d  = len_q;
    type_d = type_q;
    if (cmd_i.take) begin
      if (reject) begin
        pos_d = '0;
      end else if (store_en) begin
        pos_d = complete ? '0 : pos_inc;
        if (pos_q == afr_pkg::PosW'(2)) begin
          len_d = rx_byte_i[afr_pkg::PosW-1:0];
        end
        if (pos_q == afr_pkg::PosW'(3)) begin
          type_d = rx_byte_i;
        end
      end
    end

    idx_d = idx_q;
    if (cmd_i.take && status_o.frame_ok) begin
      idx_d = '0;
    end else if (cmd_i.advance) begin
      idx_d = idx_q + afr_pkg::IdxW'(1);
    end

    if (idx_q < afr_pkg::IdxW'(afr_pkg::AddrBytes)) begin
      raddr = afr_pkg::AddrW'(idx_q + afr_pkg::IdxW'(afr_pkg::AddrAt));
    end else begin
      raddr = afr_pkg::AddrW'(idx_q + afr_pkg::IdxW'(afr_pkg::PayloadAt - afr_pkg::AddrBytes));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      idx_q <= '0;
    end else begin
      pos_q <= pos_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    type_q <= type_d;
    if (store_en && (pos_q >= afr_pkg::PosW'(3))) begin
      sum_q <= sum_d;
    end
    if (cmd_i.load) begin
      out_byte_o   <= rdata;
      out_index_o  <= idx_q;
      is_address_o <= idx_q < afr_pkg::IdxW'(afr_pkg::AddrBytes);
      last_o       <= idx_q == afr_pkg::IdxW'(afr_pkg::NumOut - 1);
    end
  end

  afr_ram #(
    .Width(afr_pkg::ByteW),
    .Depth(afr_pkg::MaxFrame)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_en),
    .waddr_i(pos_q[afr_pkg::AddrW-1:0]),
    .wdata_i(rx_byte_i),
    .re_i   (cmd_i.rd),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule

`default_nettype wire

// ===== src/afr_ctrl.sv =====
// Controller of the frame receiver: hunts bytes, then reads out and sends the run.
// Uses afr_pkg; drives the datapath afr_dp through command signals.
`default_nettype none

module afr_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_tvalid_i,
  input  wire logic             m_tready_i,
  input  wire afr_pkg::status_t status_i,
  output logic                  s_tready_o,
  output logic                  m_tvalid_o,
  output afr_pkg::cmd_t         cmd_o
);

  afr_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      afr_pkg::StRx: begin
        if (s_tvalid_i && status_i.frame_ok) begin
          state_d = afr_pkg::StRead;
        end
      end
      afr_pkg::StRead: state_d = afr_pkg::StLoad;
      afr_pkg::StLoad: state_d = afr_pkg::StSend;
      afr_pkg::StSend: begin
        if (m_tready_i) begin
          state_d = status_i.out_last ? afr_pkg::StRx : afr_pkg::StRead;
        end
      end
      default: state_d = afr_pkg::StRx;
    endcase
  end

  always_comb begin
    s_tready_o    = state_q == afr_pkg::StRx;
    m_tvalid_o    = state_q == afr_pkg::StSend;
    cmd_o.take    = s_tvalid_i && (state_q == afr_pkg::StRx);
    cmd_o.rd      = state_q == afr_pkg::StRead;
    cmd_o.load    = state_q == afr_pkg::StLoad;
    cmd_o.advance = m_tready_i && (state_q == afr_pkg::StSend);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afr_pkg::StRx;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/afr_chk.sv =====
// Port-level checker for the API frame receiver, bound to the top level.
// Depends only on the ports of api_frame_receiver.
`default_nettype none

module afr_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  // No new byte is taken while a run is being sent.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a result is pending");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // A run carries on until its last byte has gone.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> !s_axis_tready_o)
    else $error("input reopened before the run ended");

  // After the last byte the parser is ready for the next frame.
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> s_axis_tready_o)
    else $error("input not reopened after the run");

  // Payload follows the address, so an address byte never closes a run.
  a_addr_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> !m_axis_tlast_o)
    else $error("address byte marked last");

endmodule

bind api_frame_receiver afr_chk u_afr_chk (.*);

`default_nettype wire
